>>> src/lsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types, constants and the control program of the Legendre symbol unit.
// ----------------------------------------------------------------------------
package lsu_pkg;

	// symbol encodings, two's complement in two bits
	localparam logic [1:0] SYM_ZERO = 2'b00;
	localparam logic [1:0] SYM_POS  = 2'b01;
	localparam logic [1:0] SYM_NEG  = 2'b11;

	// constants of the special cases
	localparam int MOD_TWO    = 2;
	localparam int RES_TWO    = 2;
	localparam logic [2:0] MOD8_ONE   = 3'd1;
	localparam logic [2:0] MOD8_SEVEN = 3'd7;
	localparam logic [1:0] MOD4_ONE   = 2'd1;

	// program layout
	localparam int PC_W     = 3;
	localparam int PROG_LEN = 6;

	localparam logic [PC_W-1:0] STEP_LOAD   = 3'd0;
	localparam logic [PC_W-1:0] STEP_DIV    = 3'd1;
	localparam logic [PC_W-1:0] STEP_FIX    = 3'd2;
	localparam logic [PC_W-1:0] STEP_CLASS  = 3'd3;
	localparam logic [PC_W-1:0] STEP_SEARCH = 3'd4;
	localparam logic [PC_W-1:0] STEP_EMIT   = 3'd5;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_DIV,
		OP_FIX,
		OP_CLASS,
		OP_SEARCH,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_INPUT,
		COND_BITS_LEFT,
		COND_DECIDED,
		COND_SEARCH_BUSY,
		COND_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// datapath flags tested by the sequencer
	typedef struct packed {
		logic no_input;
		logic bits_left;
		logic decided;
		logic search_busy;
		logic out_blocked;
	} status_t;

	// control store: jump to target when the condition holds, else next step
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			STEP_LOAD:   w = '{op: OP_LOAD,   cond: COND_NO_INPUT,    target: STEP_LOAD};
			STEP_DIV:    w = '{op: OP_DIV,    cond: COND_BITS_LEFT,   target: STEP_DIV};
			STEP_FIX:    w = '{op: OP_FIX,    cond: COND_NEVER,       target: STEP_LOAD};
			STEP_CLASS:  w = '{op: OP_CLASS,  cond: COND_DECIDED,     target: STEP_EMIT};
			STEP_SEARCH: w = '{op: OP_SEARCH, cond: COND_SEARCH_BUSY, target: STEP_SEARCH};
			STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BLOCKED, target: STEP_EMIT};
			default:     w = '{op: OP_LOAD,   cond: COND_NEVER,       target: STEP_LOAD};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

>>> src/lsu_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsu_sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module lsu_sequencer import lsu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire status_t status,
	output op_t          op
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          word;
	logic            jump;

	assign word = ucode_rom(pc_q);
	assign op   = word.op;

	always_comb begin
		case (word.cond)
			COND_NEVER:       jump = 1'b0;
			COND_NO_INPUT:    jump = status.no_input;
			COND_BITS_LEFT:   jump = status.bits_left;
			COND_DECIDED:     jump = status.decided;
			COND_SEARCH_BUSY: jump = status.search_busy;
			COND_OUT_BLOCKED: jump = status.out_blocked;
			default:          jump = 1'b0;
		endcase
	end

	// the last step wraps to the first
	always_comb begin
		if (jump) begin
			pc_next = word.target;
		end else if (pc_q == PC_W'(PROG_LEN - 1)) begin
			pc_next = STEP_LOAD;
		end else begin
			pc_next = pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_LOAD;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
`default_nettype wire

>>> src/lsu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsu_datapath
// Bit-serial reduction, sign fix, special-case decode, square search and output word.
// ----------------------------------------------------------------------------
module lsu_datapath import lsu_pkg::*; #(
	parameter int NUM_WIDTH = 32,
	parameter int MOD_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire op_t                  op,
	input  wire logic                 in_valid,
	input  wire logic [NUM_WIDTH-1:0] number,
	input  wire logic [MOD_WIDTH-1:0] modulus,
	input  wire logic                 out_stall,
	output status_t                   status,
	output logic                      out_valid,
	output logic [1:0]                symbol
);

	localparam int CNT_W = $clog2(NUM_WIDTH);

	logic [NUM_WIDTH-1:0] mag_q;
	logic                 neg_q;
	logic [MOD_WIDTH-1:0] p_q;
	logic [MOD_WIDTH-1:0] rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MOD_WIDTH-1:0] half_q;
	logic [MOD_WIDTH-1:0] i_q;
	logic [MOD_WIDTH-1:0] odd_q;
	logic [MOD_WIDTH-1:0] s_q;
	logic [1:0]           res_q;
	logic                 out_valid_q;
	logic [1:0]           symbol_q;

	logic [MOD_WIDTH:0]   p_ext;
	logic [MOD_WIDTH:0]   rem_sh;
	logic [MOD_WIDTH-1:0] rem_div;
	logic [MOD_WIDTH+2:0] p_wide;
	logic [2:0]           p_lo3;
	logic                 decided;
	logic [1:0]           cls_sym;
	logic [MOD_WIDTH:0]   sum;
	logic [MOD_WIDTH-1:0] s_next;
	logic                 found;
	logic                 last;
	logic                 out_blocked;

	assign p_ext  = {1'b0, p_q};
	assign p_wide = {3'b000, p_q};
	assign p_lo3  = p_wide[2:0];

	// one restoring division step per cycle
	assign rem_sh = {rem_q, mag_q[NUM_WIDTH-1]};
	always_comb begin
		if (rem_sh >= p_ext) begin
			rem_div = MOD_WIDTH'(rem_sh - p_ext);
		end else begin
			rem_div = rem_sh[MOD_WIDTH-1:0];
		end
	end

	always_comb begin
		decided = 1'b1;
		cls_sym = SYM_ZERO;
		if (p_q == '0 || rem_q == '0) begin
			cls_sym = SYM_ZERO;
		end else if (p_q == MOD_WIDTH'(MOD_TWO)) begin
			cls_sym = SYM_POS;
		end else if (rem_q == MOD_WIDTH'(RES_TWO)) begin
			cls_sym = (p_lo3 == MOD8_ONE || p_lo3 == MOD8_SEVEN) ? SYM_POS : SYM_NEG;
		end else if (rem_q == p_q - MOD_WIDTH'(1)) begin
			cls_sym = (p_lo3[1:0] == MOD4_ONE) ? SYM_POS : SYM_NEG;
		end else begin
			decided = 1'b0;
		end
	end

	// running square: i*i = (i-1)*(i-1) + (2i-1), kept reduced mod p
	assign sum = {1'b0, s_q} + {1'b0, odd_q};
	always_comb begin
		if (sum >= p_ext) begin
			s_next = MOD_WIDTH'(sum - p_ext);
		end else begin
			s_next = sum[MOD_WIDTH-1:0];
		end
	end
	assign found = (s_next == rem_q);
	assign last  = (i_q == half_q);

	assign out_blocked = out_valid_q && out_stall;

	assign status.no_input    = !in_valid;
	assign status.bits_left   = (cnt_q != '0);
	assign status.decided     = decided;
	assign status.search_busy = !found && !last;
	assign status.out_blocked = out_blocked;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (in_valid) begin
					neg_q <= number[NUM_WIDTH-1];
					mag_q <= number[NUM_WIDTH-1] ? (~number + NUM_WIDTH'(1)) : number;
					p_q   <= modulus;
					rem_q <= '0;
					cnt_q <= CNT_W'(NUM_WIDTH - 1);
				end
			end
			OP_DIV: begin
				rem_q <= rem_div;
				mag_q <= mag_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_FIX: begin
				if (neg_q && rem_q != '0) begin
					rem_q <= p_q - rem_q;
				end
			end
			OP_CLASS: begin
				res_q  <= cls_sym;
				half_q <= p_q >> 1;
				i_q    <= MOD_WIDTH'(1);
				odd_q  <= MOD_WIDTH'(1);
				s_q    <= '0;
			end
			OP_SEARCH: begin
				s_q   <= s_next;
				i_q   <= i_q + MOD_WIDTH'(1);
				odd_q <= odd_q + MOD_WIDTH'(2);
				res_q <= found ? SYM_POS : SYM_NEG;
			end
			OP_EMIT: begin
				if (!out_blocked) begin
					symbol_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT && !out_blocked) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;

	a_sym_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> symbol_q != 2'b10)
		else $error("output word carries an invalid symbol code");

	a_square_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_SEARCH |-> s_q < p_q)
		else $error("running square not reduced below modulus");

	a_search_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_SEARCH |-> (i_q <= half_q && i_q != '0))
		else $error("search index outside 1..p/2");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT && !out_blocked) |=> out_valid_q)
		else $error("emitted word not presented");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && op != OP_EMIT) |=> !out_valid_q)
		else $error("taken word presented again");

endmodule
`default_nettype wire

>>> src/legendre_symbol_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// legendre_symbol_unit_core
// Legendre symbol of a signed number with respect to a positive modulus.
// ----------------------------------------------------------------------------
// Input channel: number (signed) and modulus with in_valid / in_stall. A word
// is taken when in_valid is high and in_stall is low; in_stall is low only
// while the sequencer sits on its load step.
// Output channel: symbol (01 residue, 11 non-residue, 00 divisible) with
// out_valid / out_stall, held in an output register until taken.
// Steps: a load step, bit-serial reduction over all NUM_WIDTH bits of the
// number, a sign fix, a special-case decode, then a search over candidates
// from 1 up to modulus/2 (one candidate square per cycle), then an emit step
// that writes the output register; special cases skip the search. One word
// is in work at a time, and the search loop sets the throughput.
// While the receiver stalls, a finished word waits in the output register and
// the next input word is still taken; a second finished word waits on the
// emit step until the register frees up.
// Reset clears the step counter to the load step and drops out_valid.
// ----------------------------------------------------------------------------
module legendre_symbol_unit_core import lsu_pkg::*; #(
	parameter int NUM_WIDTH = 32,
	parameter int MOD_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [NUM_WIDTH-1:0] number,
	input  wire logic [MOD_WIDTH-1:0] modulus,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                symbol
);

	op_t     op;
	status_t status;

	assign in_stall = (op != OP_LOAD);

	lsu_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	lsu_datapath #(
		.NUM_WIDTH (NUM_WIDTH),
		.MOD_WIDTH (MOD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_valid  (in_valid),
		.number    (number),
		.modulus   (modulus),
		.out_stall (out_stall),
		.status    (status),
		.out_valid (out_valid),
		.symbol    (symbol)
	);

endmodule
`default_nettype wire
